>>> rtl/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the strict UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_LEAD    = 3'd1,
    ST_TRUNCATED   = 3'd2,
    ST_BAD_CONT    = 3'd3,
    ST_OVERLONG    = 3'd4,
    ST_SURROGATE   = 3'd5,
    ST_RANGE       = 3'd6,
    ST_DROPPED_END = 3'd7
  } status_t;

  // One input beat: a raw byte and its end-of-string flag.
  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_string;
  } byte_beat_t;

  // One result beat.
  typedef struct packed {
    logic [15:0] code_unit;
    status_t     status;
    logic        run_last;
    logic        string_done;
  } unit_beat_t;

  localparam logic [20:0] SURR_LO   = 21'h00D800;
  localparam logic [20:0] SURR_HI   = 21'h00DFFF;
  localparam logic [20:0] CP_MAX    = 21'h10FFFF;
  localparam logic [20:0] BMP_MAX   = 21'h00FFFF;
  localparam logic [20:0] PLANE1    = 21'h010000;
  localparam logic [15:0] HIGH_BASE = 16'hD800;
  localparam logic [15:0] LOW_BASE  = 16'hDC00;

  // Smallest code point allowed for a sequence with the given number of
  // continuation bytes.
  function automatic logic [20:0] overlong_min(input logic [1:0] seq_len);
    case (seq_len)
      2'd1:    overlong_min = 21'h000080;
      2'd2:    overlong_min = 21'h000800;
      2'd3:    overlong_min = 21'h010000;
      default: overlong_min = 21'h000000;
    endcase
  endfunction

endpackage

>>> rtl/utf8_to_utf16_transcoder.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// Strict UTF-8 to UTF-16 transcoder taking one byte per beat.
// ----------------------------------------------------------------------------
// Each result is registered into the result queue when its byte is taken.
// Throughput: one byte per cycle while byte_stall is low; a surrogate pair
// fills two queue entries. The four-entry result queue stalls input while it
// holds more than two results; pairs drain one unit per cycle when unstalled.
// Reset clears the decode state and empties the result queue.
module utf8_to_utf16_transcoder
  import u8u16_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  byte_beat_t byte_beat,
  output logic       unit_valid,
  input  logic       unit_stall,
  output unit_beat_t unit_beat
);

  // Decode state.
  logic [20:0] partial_point, partial_point_next;
  logic [1:0]  bytes_due, bytes_due_next;
  logic [1:0]  sequence_length, sequence_length_next;
  logic        discarding, discarding_next;

  // Result queue.
  unit_beat_t  queue_mem [4];
  logic [1:0]  head, tail;
  logic [2:0]  count, count_next;

  logic        accept;
  logic        pop;
  logic [1:0]  push_n;
  unit_beat_t  res0, res1;

  // Decode scratch values.
  logic        is_end;
  logic [7:0]  b;
  logic [20:0] shifted_point;
  logic [20:0] cp_off;
  logic        err;
  status_t     err_status;
  logic [1:0]  due_dec;

  assign accept     = byte_valid && !byte_stall;
  assign pop        = unit_valid && !unit_stall;
  assign byte_stall = (count > 3'd2);
  assign unit_valid = (count != 3'd0);
  assign unit_beat  = queue_mem[head];

  assign is_end        = byte_beat.end_of_string;
  assign b             = byte_beat.byte_value;
  assign shifted_point = {partial_point[14:0], b[5:0]};
  assign cp_off        = shifted_point - PLANE1;
  assign due_dec       = bytes_due - 2'd1;

  // Decode one byte into up to two results and the next state.
  always_comb begin
    partial_point_next   = partial_point;
    bytes_due_next       = bytes_due;
    sequence_length_next = sequence_length;
    discarding_next      = discarding;
    push_n               = 2'd0;
    res0                 = '0;
    res1                 = '0;
    err                  = 1'b0;
    err_status           = ST_OK;

    if (accept) begin
      if (discarding) begin
        // Drop bytes after an error; the end byte closes the string.
        if (is_end) begin
          push_n           = 2'd1;
          res0.status      = ST_DROPPED_END;
          res0.run_last    = 1'b1;
          res0.string_done = 1'b1;
          discarding_next  = 1'b0;
        end
      end else if (bytes_due == 2'd0) begin
        // Lead byte.
        if (!b[7]) begin
          push_n           = 2'd1;
          res0.code_unit   = {8'h00, b};
          res0.status      = ST_OK;
          res0.run_last    = 1'b1;
          res0.string_done = is_end;
        end else if (b[7:5] == 3'b110) begin
          if (is_end) begin
            err = 1'b1; err_status = ST_TRUNCATED;
          end else begin
            partial_point_next   = {16'h0000, b[4:0]};
            bytes_due_next       = 2'd1;
            sequence_length_next = 2'd1;
          end
        end else if (b[7:4] == 4'b1110) begin
          if (is_end) begin
            err = 1'b1; err_status = ST_TRUNCATED;
          end else begin
            partial_point_next   = {17'h00000, b[3:0]};
            bytes_due_next       = 2'd2;
            sequence_length_next = 2'd2;
          end
        end else if (b[7:3] == 5'b11110) begin
          if (is_end) begin
            err = 1'b1; err_status = ST_TRUNCATED;
          end else begin
            partial_point_next   = {18'h00000, b[2:0]};
            bytes_due_next       = 2'd3;
            sequence_length_next = 2'd3;
          end
        end else begin
          err = 1'b1; err_status = ST_BAD_LEAD;
        end
      end else if (b[7:6] != 2'b10) begin
        // A continuation byte was due but something else came.
        err = 1'b1; err_status = ST_BAD_CONT;
      end else if (due_dec != 2'd0) begin
        // Sequence still open.
        if (is_end) begin
          err = 1'b1; err_status = ST_TRUNCATED;
        end else begin
          partial_point_next = shifted_point;
          bytes_due_next     = due_dec;
        end
      end else begin
        // Sequence complete: validate and emit.
        if (shifted_point < overlong_min(sequence_length)) begin
          err = 1'b1; err_status = ST_OVERLONG;
        end else if (shifted_point >= SURR_LO && shifted_point <= SURR_HI) begin
          err = 1'b1; err_status = ST_SURROGATE;
        end else if (shifted_point > CP_MAX) begin
          err = 1'b1; err_status = ST_RANGE;
        end else if (shifted_point <= BMP_MAX) begin
          push_n           = 2'd1;
          res0.code_unit   = shifted_point[15:0];
          res0.status      = ST_OK;
          res0.run_last    = 1'b1;
          res0.string_done = is_end;
        end else begin
          push_n           = 2'd2;
          res0.code_unit   = HIGH_BASE | {6'h00, cp_off[19:10]};
          res0.status      = ST_OK;
          res1.code_unit   = LOW_BASE | {6'h00, cp_off[9:0]};
          res1.status      = ST_OK;
          res1.run_last    = 1'b1;
          res1.string_done = is_end;
        end
        partial_point_next   = '0;
        bytes_due_next       = 2'd0;
        sequence_length_next = 2'd0;
      end

      // Any error clears the state and reports once.
      if (err) begin
        partial_point_next   = '0;
        bytes_due_next       = 2'd0;
        sequence_length_next = 2'd0;
        res0.code_unit       = '0;
        res0.status          = err_status;
        if (is_end) begin
          push_n           = 2'd2;
          res0.run_last    = 1'b0;
          res0.string_done = 1'b0;
          res1.code_unit   = '0;
          res1.status      = ST_DROPPED_END;
          res1.run_last    = 1'b1;
          res1.string_done = 1'b1;
          discarding_next  = 1'b0;
        end else begin
          push_n           = 2'd1;
          res0.run_last    = 1'b1;
          res0.string_done = 1'b0;
          discarding_next  = 1'b1;
        end
      end else if (is_end) begin
        // The end byte always leaves the reset state behind.
        partial_point_next   = '0;
        bytes_due_next       = 2'd0;
        sequence_length_next = 2'd0;
        discarding_next      = 1'b0;
      end
    end
  end

  assign count_next = count + {1'b0, push_n} - {2'b00, pop};

  // Decode state and queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      partial_point   <= '0;
      bytes_due       <= 2'd0;
      sequence_length <= 2'd0;
      discarding      <= 1'b0;
      head            <= 2'd0;
      tail            <= 2'd0;
      count           <= 3'd0;
    end else begin
      partial_point   <= partial_point_next;
      bytes_due       <= bytes_due_next;
      sequence_length <= sequence_length_next;
      discarding      <= discarding_next;
      tail            <= tail + push_n;
      if (pop) begin
        head <= head + 2'd1;
      end
      count <= count_next;
    end
  end

  // Result queue storage.
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      queue_mem[tail] <= res0;
    end
    if (push_n == 2'd2) begin
      queue_mem[tail + 2'd1] <= res1;
    end
  end

  // The queue never overfills.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4)
    else $error("result queue count exceeds its depth");

  // An accepted end byte always produces at least one result.
  a_end_yields: assert property (@(posedge clk) disable iff (rst)
    (accept && byte_beat.end_of_string) |-> (push_n != 2'd0))
    else $error("end byte produced no result");

  // After an end byte the decoder is back in its reset state.
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && byte_beat.end_of_string) |=>
      (bytes_due == 2'd0 && !discarding && sequence_length == 2'd0))
    else $error("state not cleared after end byte");

  // While dropping bytes, only the end byte gives a result.
  a_discard_quiet: assert property (@(posedge clk) disable iff (rst)
    (accept && discarding && !byte_beat.end_of_string) |-> (push_n == 2'd0))
    else $error("result produced while discarding");

endmodule
